// ===== hw/rtl/gwc_pkg.sv =====
// ----------------------------------------------------------------------------
// gwc_pkg
// Shared constants for the greedy weighted-completion scheduler.
// ----------------------------------------------------------------------------
package gwc_pkg;

  localparam int DEF_MAX_JOBS = 1024;
  localparam int FIELD_W      = 16;
  localparam int TOTAL_W      = 52;
  localparam int COUNT_OUT_W  = 11;
  localparam int JOB_W        = 2 * FIELD_W;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

endpackage

// ===== hw/rtl/greedy_weighted_completion_scheduler_unit.sv =====
// Loading: jobs load at one item per cycle; after the last job the schedule
//   is built by one full memory scan per stored job.
// Throughput: one job per cycle while loading; one result per set.
// The memory read port sets the scan rate: one stored job compared per cycle.
// Reset clears the job count, the drop flag, the state and the output valid;
//   job memory is not cleared.
// ----------------------------------------------------------------------------
// greedy_weighted_completion_scheduler_unit
// Stores jobs, picks them in greedy order by repeated scans of the job memory
// and sums completion time times weight.
// ----------------------------------------------------------------------------
module greedy_weighted_completion_scheduler_unit
  import gwc_pkg::*;
#(
  parameter int MAX_JOBS = DEF_MAX_JOBS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [FIELD_W-1:0]     job_weight,
  input  logic [FIELD_W-1:0]     job_length,
  input  logic                   last_job,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [TOTAL_W-1:0]     weighted_total,
  output logic [COUNT_OUT_W-1:0] jobs_counted,
  output logic                   overflow
);

  localparam int AW   = $clog2(MAX_JOBS);
  localparam int CNTW = $clog2(MAX_JOBS + 1);
  localparam int CW   = FIELD_W + CNTW;
  localparam int PW   = CW + FIELD_W;
  localparam int SW   = ((PW > TOTAL_W) ? PW : TOTAL_W) + 1;

  localparam logic [2:0] ST_LOAD = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_PROD = 3'd3;
  localparam logic [2:0] ST_ADD  = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0]         state;
  logic [CNTW-1:0]    count;
  logic               dropped;
  logic [CNTW-1:0]    scan_cnt;
  logic [CNTW-1:0]    placed;
  logic               rv;
  logic [AW-1:0]      rv_idx;
  logic               cand_valid;
  logic [FIELD_W-1:0] cand_w, cand_l;
  logic [AW-1:0]      cand_idx;
  logic               prev_valid;
  logic [FIELD_W-1:0] prev_w, prev_l;
  logic [AW-1:0]      prev_idx;
  logic [CW-1:0]      comp;
  logic [FIELD_W-1:0] mul_w;
  logic [PW-1:0]      prod;
  logic [TOTAL_W-1:0] total;

  logic               in_acc, has_room, issue;
  logic [JOB_W-1:0]   rd_data;
  logic [FIELD_W-1:0] cur_w, cur_l;
  logic               eligible, better;
  logic [SW-1:0]      sum;
  logic [CNTW+COUNT_OUT_W-1:0] cnt_wide;

  // a goes strictly before b in greedy order
  function automatic logic goes_before(
    input logic [FIELD_W-1:0] wa, input logic [FIELD_W-1:0] la, input logic [AW-1:0] ia,
    input logic [FIELD_W-1:0] wb, input logic [FIELD_W-1:0] lb, input logic [AW-1:0] ib);
    logic signed [FIELD_W:0] sa, sb;
    logic r;
    sa = $signed({1'b0, wa}) - $signed({1'b0, la});
    sb = $signed({1'b0, wb}) - $signed({1'b0, lb});
    if (sa != sb) r = (sa > sb);
    else if (wa != wb) r = (wa > wb);
    else r = (ia < ib);
    return r;
  endfunction

  assign in_stall = (state != ST_LOAD);
  assign in_acc   = in_valid && !in_stall;
  assign has_room = (count < CNTW'(MAX_JOBS));
  assign issue    = (state == ST_SCAN) && (scan_cnt < count);

  gwc_store #(.DEPTH(MAX_JOBS), .AW(AW)) u_store (
    .clk    (clk),
    .wr_en  (in_acc && has_room),
    .wr_addr(count[AW-1:0]),
    .wr_data({job_weight, job_length}),
    .rd_en  (issue),
    .rd_addr(scan_cnt[AW-1:0]),
    .rd_data(rd_data)
  );

  // selection compare on returned entry
  always_comb begin
    cur_w    = rd_data[JOB_W-1:FIELD_W];
    cur_l    = rd_data[FIELD_W-1:0];
    eligible = !prev_valid ||
               goes_before(prev_w, prev_l, prev_idx, cur_w, cur_l, rv_idx);
    better   = !cand_valid ||
               goes_before(cur_w, cur_l, rv_idx, cand_w, cand_l, cand_idx);
    sum      = SW'(total) + SW'(prod);
    cnt_wide = (CNTW+COUNT_OUT_W)'(count);
  end

  // control and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      count      <= '0;
      dropped    <= 1'b0;
      rv         <= 1'b0;
      out_valid  <= 1'b0;
      cand_valid <= 1'b0;
      prev_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      rv <= issue;
      case (state)
        ST_LOAD: begin
          if (in_acc) begin
            if (has_room) count <= count + 1'b1;
            else dropped <= 1'b1;
            if (last_job) begin
              scan_cnt   <= '0;
              placed     <= '0;
              cand_valid <= 1'b0;
              prev_valid <= 1'b0;
              comp       <= '0;
              total      <= '0;
              state      <= (has_room || count != '0) ? ST_SCAN : ST_OUT;
            end
          end
        end
        ST_SCAN: begin
          if (issue) scan_cnt <= scan_cnt + 1'b1;
          if (rv) begin
            if (eligible && better) begin
              cand_valid <= 1'b1;
              cand_w     <= cur_w;
              cand_l     <= cur_l;
              cand_idx   <= rv_idx;
            end
            if (CNTW'(rv_idx) == count - 1'b1) state <= ST_MUL;
          end
        end
        ST_MUL: begin
          prev_valid <= 1'b1;
          prev_w     <= cand_w;
          prev_l     <= cand_l;
          prev_idx   <= cand_idx;
          comp       <= comp + CW'(cand_l);
          mul_w      <= cand_w;
          state      <= ST_PROD;
        end
        ST_PROD: begin
          prod  <= PW'(comp) * PW'(mul_w);
          state <= ST_ADD;
        end
        ST_ADD: begin
          total      <= (sum > SW'(TOTAL_MAX)) ? TOTAL_MAX : sum[TOTAL_W-1:0];
          placed     <= placed + 1'b1;
          scan_cnt   <= '0;
          cand_valid <= 1'b0;
          state      <= (placed + 1'b1 == count) ? ST_OUT : ST_SCAN;
        end
        ST_OUT: begin
          // wait until the previous result has been taken
          if (!out_valid || !out_stall) begin
            out_valid      <= 1'b1;
            weighted_total <= total;
            jobs_counted   <= cnt_wide[COUNT_OUT_W-1:0];
            overflow       <= dropped;
            count          <= '0;
            dropped        <= 1'b0;
            state          <= ST_LOAD;
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

  // read pipeline index
  always_ff @(posedge clk) begin
    rv_idx <= scan_cnt[AW-1:0];
  end

endmodule

// ===== hw/rtl/gwc_store.sv =====
// ----------------------------------------------------------------------------
// gwc_store
// Job memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module gwc_store
  import gwc_pkg::*;
#(
  parameter int DEPTH = DEF_MAX_JOBS,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [JOB_W-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [JOB_W-1:0] rd_data
);

  logic [JOB_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
